// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// every check samples on clk and is held off while rst_n is low
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/imt_pkg.sv -----
package imt_pkg;

    typedef enum logic [2:0] {
        ST_START  = 3'd0,
        ST_NICK   = 3'd1,
        ST_USER   = 3'd2,
        ST_HOST   = 3'd3,
        ST_CMD    = 3'd4,
        ST_PARAMS = 3'd5,
        ST_TRAIL  = 3'd6,
        ST_CRWAIT = 3'd7
    } parser_state_t;

    typedef enum logic [2:0] {
        KIND_DELIM   = 3'd0,
        KIND_NICK    = 3'd1,
        KIND_USER    = 3'd2,
        KIND_HOST    = 3'd3,
        KIND_CMD     = 3'd4,
        KIND_MIDDLE  = 3'd5,
        KIND_TRAIL   = 3'd6
    } field_kind_t;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [7:0]  out_byte;
        field_kind_t field_kind;
        logic [3:0]  param_index;
        logic        param_done;
        logic        message_done;
        logic        parse_error;
    } imt_result_t;

endpackage

// ----- sv/imt_ifs.sv -----
interface imt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface imt_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic [3:0] param_index;
    logic       param_done;
    logic       message_done;
    logic       parse_error;

    modport source (
        output valid, output out_byte, output field_kind, output param_index,
        output param_done, output message_done, output parse_error,
        input ready
    );
    modport sink (
        input valid, input out_byte, input field_kind, input param_index,
        input param_done, input message_done, input parse_error,
        output ready
    );
endinterface

// ----- sv/imt_in_stage.sv -----
module imt_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    imt_byte_if.sink   bytes_in,
    input  logic       take,
    output logic       valid,
    output logic [7:0] data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       accept;

    assign bytes_in.ready = !valid_reg || take;
    assign accept         = bytes_in.valid && bytes_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= bytes_in.in_byte;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

// ----- sv/imt_parser.sv -----
module imt_parser #(
    parameter int MAX_PARAMS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         cur_byte,
    output imt_pkg::imt_result_t res
);
    import imt_pkg::*;

    localparam int CW = (MAX_PARAMS > 2) ? $clog2(MAX_PARAMS) : 1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PARAMS - 1);

    parser_state_t state_reg;
    parser_state_t state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW+3:0] count_ext;
    logic [3:0]    count_idx;
    logic          is_ws;
    logic          is_alnum;
    parser_state_t eff_state;
    logic          consumed;

    assign count_ext = (CW + 4)'(count_reg);
    assign count_idx = count_ext[3:0];

    assign is_ws = (cur_byte == CH_SPACE) || ((cur_byte >= CH_TAB) && (cur_byte <= CH_CR));
    assign is_alnum = ((cur_byte >= 8'h61) && (cur_byte <= 8'h7A))
                   || ((cur_byte >= 8'h41) && (cur_byte <= 8'h5A))
                   || ((cur_byte >= 8'h30) && (cur_byte <= 8'h39));

    // a start byte other than colon is the first command byte
    always_comb
    begin
        consumed  = 1'b0;
        eff_state = state_reg;
        if (state_reg == ST_START)
        begin
            if (cur_byte == CH_COLON)
            begin
                consumed = 1'b1;
            end
            else
            begin
                eff_state = ST_CMD;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        if (consumed)
        begin
            state_next = ST_NICK;
        end
        else
        begin
            case (eff_state)
                ST_NICK:
                begin
                    if (is_ws)                   state_next = ST_CMD;
                    else if (cur_byte == CH_BANG) state_next = ST_USER;
                    else if (cur_byte == CH_AT)   state_next = ST_HOST;
                end
                ST_USER:
                begin
                    if (is_ws)                  state_next = ST_CMD;
                    else if (cur_byte == CH_AT) state_next = ST_HOST;
                end
                ST_HOST:
                begin
                    if (is_ws) state_next = ST_CMD;
                end
                ST_CMD:
                begin
                    if (is_alnum)
                    begin
                        state_next = ST_CMD;
                    end
                    else if (cur_byte == CH_SPACE)
                    begin
                        state_next = ST_PARAMS;
                        count_next = '0;
                    end
                    else
                    begin
                        state_next = ST_START;
                        count_next = '0;
                    end
                end
                ST_PARAMS:
                begin
                    if (cur_byte == CH_COLON)
                    begin
                        state_next = ST_TRAIL;
                    end
                    else if (cur_byte == CH_CR)
                    begin
                        state_next = ST_CRWAIT;
                    end
                    else if (cur_byte == CH_LF)
                    begin
                        state_next = ST_START;
                        count_next = '0;
                    end
                    else if (cur_byte == CH_SPACE)
                    begin
                        if (count_reg < COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                ST_TRAIL:
                begin
                    if (cur_byte == CH_NUL || cur_byte == CH_LF)
                    begin
                        state_next = ST_START;
                        count_next = '0;
                    end
                    else if (cur_byte == CH_CR)
                    begin
                        state_next = ST_CRWAIT;
                    end
                end
                ST_CRWAIT:
                begin
                    if (cur_byte == CH_LF)
                    begin
                        state_next = ST_START;
                        count_next = '0;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        res              = '0;
        res.out_byte     = cur_byte;
        res.field_kind   = KIND_DELIM;
        if (!consumed)
        begin
            case (eff_state)
                ST_NICK:
                begin
                    if (!is_ws && cur_byte != CH_BANG && cur_byte != CH_AT)
                        res.field_kind = KIND_NICK;
                end
                ST_USER:
                begin
                    if (!is_ws && cur_byte != CH_AT) res.field_kind = KIND_USER;
                end
                ST_HOST:
                begin
                    if (!is_ws) res.field_kind = KIND_HOST;
                end
                ST_CMD:
                begin
                    if (is_alnum)                   res.field_kind  = KIND_CMD;
                    else if (cur_byte != CH_SPACE) res.parse_error = 1'b1;
                end
                ST_PARAMS:
                begin
                    res.param_index = count_idx;
                    if (cur_byte == CH_COLON)
                    begin
                        res.param_done = 1'b0;
                    end
                    else if (cur_byte == CH_CR || cur_byte == CH_SPACE)
                    begin
                        res.param_done = 1'b1;
                    end
                    else if (cur_byte == CH_LF)
                    begin
                        res.param_done   = 1'b1;
                        res.message_done = 1'b1;
                    end
                    else
                    begin
                        res.field_kind = KIND_MIDDLE;
                    end
                end
                ST_TRAIL:
                begin
                    res.param_index = count_idx;
                    if (cur_byte == CH_NUL)
                    begin
                        res.parse_error = 1'b1;
                        res.param_index = '0;
                    end
                    else if (cur_byte == CH_CR)
                    begin
                        res.param_done = 1'b1;
                    end
                    else if (cur_byte == CH_LF)
                    begin
                        res.param_done   = 1'b1;
                        res.message_done = 1'b1;
                    end
                    else
                    begin
                        res.field_kind = KIND_TRAIL;
                    end
                end
                ST_CRWAIT:
                begin
                    res.param_index = count_idx;
                    if (cur_byte == CH_LF) res.message_done = 1'b1;
                end
                default:
                begin
                    res.field_kind = KIND_DELIM;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            count_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end
endmodule

// ----- sv/imt_out_stage.sv -----
module imt_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_req,
    input  imt_pkg::imt_result_t res,
    output logic                take,
    imt_tok_if.source           tokens_out
);
    import imt_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    imt_result_t res_reg;

    assign take = load_req && (!valid_reg || tokens_out.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (tokens_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
        end
    end

    assign tokens_out.valid        = valid_reg;
    assign tokens_out.out_byte     = res_reg.out_byte;
    assign tokens_out.field_kind   = res_reg.field_kind;
    assign tokens_out.param_index  = res_reg.param_index;
    assign tokens_out.param_done   = res_reg.param_done;
    assign tokens_out.message_done = res_reg.message_done;
    assign tokens_out.parse_error  = res_reg.parse_error;
endmodule

// ----- sv/irc_message_tokenizer.sv -----
// irc line tokenizer: one raw byte in, one tagged byte out
// bytes_in carries one byte of the stream per word (valid/ready)
// tokens_out carries the same byte with its field kind, parameter index
// and the param_done, message_done and parse_error flags
// each byte goes through an input register, the per-byte parser logic
// and a result register: a byte accepted into the input register is
// offered on tokens_out once the result register has loaded it
// throughput is one word per cycle while tokens_out does not stall,
// otherwise limited only by the single parser state update per byte
// when tokens_out stalls, the result register holds its word and the input
// register holds the next byte; bytes_in drops ready once both are full
// and resumes in the same cycle the receiver takes a word
// reset clears both stage valids, returns the parser to its start state
// and the parameter count to zero; words in flight are dropped
// MAX_PARAMS sets where the parameter index saturates
module irc_message_tokenizer #(
    parameter int MAX_PARAMS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    imt_byte_if.sink  bytes_in,
    imt_tok_if.source tokens_out
);
    import imt_pkg::*;

    logic        s1_valid;
    logic [7:0]  s1_byte;
    logic        advance;
    imt_result_t parsed;

    imt_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes_in (bytes_in),
        .take     (advance),
        .valid    (s1_valid),
        .data     (s1_byte)
    );

    imt_parser #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .cur_byte (s1_byte),
        .res      (parsed)
    );

    imt_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_req   (s1_valid),
        .res        (parsed),
        .take       (advance),
        .tokens_out (tokens_out)
    );
endmodule

// ----- sv/imt_checker.sv -----
`include "assert_macros.svh"

module imt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [2:0] field_kind,
    input logic       param_done,
    input logic       message_done,
    input logic       parse_error
);
    import imt_pkg::*;

    logic        stalled;
    logic [13:0] word_bits;
    logic        msg_end;
    logic        err_word;
    logic        err_flags_clear;
    logic        pdone_word;
    logic        delim_end;

    assign stalled         = out_valid && !out_ready;
    assign word_bits       = {out_byte, field_kind, param_done, message_done, parse_error};
    assign msg_end         = out_valid && message_done;
    assign err_word        = out_valid && parse_error;
    assign err_flags_clear = (field_kind == KIND_DELIM) && !param_done && !message_done;
    assign pdone_word      = out_valid && param_done;
    assign delim_end       = (field_kind == KIND_DELIM)
                          && (out_byte == CH_SPACE || out_byte == CH_CR || out_byte == CH_LF);

    // a stalled word keeps its contents
    `ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(word_bits), "stalled word changed")

    // a message only ends on line feed
    `ASSERT_IMPLY(a_done_on_lf, msg_end, out_byte == CH_LF, "message_done without line feed")

    // an error word carries no tag and no done flags
    `ASSERT_IMPLY(a_err_clean, err_word, err_flags_clear, "error word not clean")

    // the byte that closes a parameter is a delimiter
    `ASSERT_IMPLY(a_pdone_delim, pdone_word, delim_end, "param_done on a field byte")
endmodule

bind irc_message_tokenizer imt_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (tokens_out.valid),
    .out_ready    (tokens_out.ready),
    .out_byte     (tokens_out.out_byte),
    .field_kind   (tokens_out.field_kind),
    .param_done   (tokens_out.param_done),
    .message_done (tokens_out.message_done),
    .parse_error  (tokens_out.parse_error)
);
